// ===== src/assert_macros.svh =====
// Assertion macros shared by the recognizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Check cons in the cycle after ante.
`define ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tgpr_pkg.sv =====
// Grammar state codes, token codes and the per-token transition function.
package tgpr_pkg;

    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_INVALID  = 4'd1;
    localparam logic [3:0] S_END      = 4'd2;
    localparam logic [3:0] S_HELPER   = 4'd3;
    localparam logic [3:0] S_VNAME    = 4'd4;
    localparam logic [3:0] S_VCOLON   = 4'd5;
    localparam logic [3:0] S_DAT      = 4'd6;
    localparam logic [3:0] S_DATNAME  = 4'd7;
    localparam logic [3:0] S_DATID    = 4'd8;
    localparam logic [3:0] S_ASSIGN   = 4'd9;
    localparam logic [3:0] S_ASSIGNEQ = 4'd10;
    localparam logic [3:0] S_FUN      = 4'd11;
    localparam logic [3:0] S_FUNNAME  = 4'd12;
    localparam logic [3:0] S_FUNARGS  = 4'd13;
    localparam logic [3:0] S_FUNCOMMA = 4'd14;
    localparam logic [3:0] S_FUNEND   = 4'd15;

    localparam logic [4:0] T_INVALID     = 5'd0;
    localparam logic [4:0] T_END         = 5'd1;
    localparam logic [4:0] T_COMMENT     = 5'd2;
    localparam logic [4:0] T_EMPTY       = 5'd3;
    localparam logic [4:0] T_COLON       = 5'd4;
    localparam logic [4:0] T_TYPE        = 5'd5;
    localparam logic [4:0] T_NOP         = 5'd6;
    localparam logic [4:0] T_IDENT       = 5'd7;
    localparam logic [4:0] T_KEYWORD     = 5'd8;
    localparam logic [4:0] T_COMMA       = 5'd9;
    localparam logic [4:0] T_ASSIGNOP    = 5'd10;
    localparam logic [4:0] T_CONST_FIRST = 5'd11;
    localparam logic [4:0] T_CONST_LAST  = 5'd16;
    localparam logic [4:0] T_EXPR_BEGIN  = 5'd17;
    localparam logic [4:0] T_EXPR_END    = 5'd18;

    localparam logic [1:0] K_DAT = 2'd1;
    localparam logic [1:0] K_END = 2'd2;
    localparam logic [1:0] K_FUN = 2'd3;

    // Outcome of judging one token in one state
    localparam logic [1:0] ACT_GO    = 2'd0;
    localparam logic [1:0] ACT_PUSH  = 2'd1;
    localparam logic [1:0] ACT_RETRY = 2'd2;

    typedef struct packed {
        logic [1:0] act;
        logic [3:0] state;
        logic       acc;
        logic [3:0] ret;
    } judge_t;

    function automatic judge_t judge(input logic [3:0] st, input logic [4:0] tok,
                                     input logic [1:0] kw, input logic stacked);
        judge_t j;
        logic   is_kw;
        j.act   = ACT_GO;
        j.state = S_INVALID;
        j.acc   = 1'b0;
        j.ret   = S_IDLE;
        is_kw   = (tok == T_KEYWORD);
        if (tok == T_INVALID) begin
            j.state = S_INVALID;
        end else if (tok == T_END) begin
            j.state = S_END;
        end else if (tok == T_COMMENT || tok == T_EMPTY) begin
            j.state = st;
            j.acc   = (st != S_INVALID);
        end else begin
            unique case (st)
                S_VNAME: begin
                    if (tok == T_COLON) begin
                        j.state = S_VCOLON; j.acc = 1'b1;
                    end
                end
                S_VCOLON: begin
                    if (tok == T_TYPE) begin
                        j.state = S_HELPER; j.acc = 1'b1;
                    end
                end
                S_IDLE: begin
                    if (tok == T_NOP) begin
                        j.state = S_IDLE; j.acc = 1'b1;
                    end else if (tok == T_IDENT) begin
                        j.act = ACT_PUSH; j.ret = S_ASSIGN; j.state = S_VNAME; j.acc = 1'b1;
                    end else if (is_kw && kw == K_DAT) begin
                        j.state = S_DAT; j.acc = 1'b1;
                    end else if (stacked) begin
                        j.act = ACT_RETRY;
                    end
                end
                S_DAT: begin
                    if (tok == T_IDENT) begin
                        j.state = S_DATNAME; j.acc = 1'b1;
                    end
                end
                S_DATNAME: begin
                    if (tok == T_IDENT) begin
                        j.act = ACT_PUSH; j.ret = S_DATID; j.state = S_VNAME; j.acc = 1'b1;
                    end
                end
                S_DATID: begin
                    if (tok == T_COMMA) begin
                        j.state = S_DATNAME; j.acc = 1'b1;
                    end else if (is_kw && kw == K_END) begin
                        j.state = S_IDLE; j.acc = 1'b1;
                    end
                end
                S_ASSIGN: begin
                    if (tok == T_ASSIGNOP) begin
                        j.state = S_ASSIGNEQ; j.acc = 1'b1;
                    end
                end
                S_ASSIGNEQ: begin
                    if (tok >= T_CONST_FIRST && tok <= T_CONST_LAST) begin
                        j.state = S_IDLE; j.acc = 1'b1;
                    end else if (is_kw && kw == K_FUN) begin
                        j.state = S_FUN; j.acc = 1'b1;
                    end
                end
                S_FUN: begin
                    if (tok == T_IDENT) begin
                        j.state = S_FUNNAME; j.acc = 1'b1;
                    end else if (tok == T_EXPR_BEGIN) begin
                        j.state = S_FUNARGS; j.acc = 1'b1;
                    end
                end
                S_FUNNAME: begin
                    if (tok == T_EXPR_BEGIN) begin
                        j.state = S_FUNARGS; j.acc = 1'b1;
                    end
                end
                S_FUNARGS: begin
                    if (tok == T_IDENT) begin
                        j.act = ACT_PUSH; j.ret = S_FUNCOMMA; j.state = S_VNAME; j.acc = 1'b1;
                    end else if (tok == T_EXPR_END) begin
                        j.act = ACT_PUSH; j.ret = S_FUNEND; j.state = S_IDLE; j.acc = 1'b1;
                    end
                end
                S_FUNCOMMA: begin
                    if (tok == T_COMMA) begin
                        j.state = S_FUNARGS; j.acc = 1'b1;
                    end else if (tok == T_EXPR_END) begin
                        j.act = ACT_PUSH; j.ret = S_FUNEND; j.state = S_IDLE; j.acc = 1'b1;
                    end
                end
                S_FUNEND: begin
                    if (is_kw && kw == K_END) begin
                        j.state = S_IDLE; j.acc = 1'b1;
                    end
                end
                default: begin
                    j.state = S_INVALID;
                end
            endcase
        end
        return j;
    endfunction

endpackage

// ===== src/token_grammar_pushdown_recognizer_unit.sv =====
// Recognizer top level: grammar state, stack memory control and result buffer.
//
// Checks a stream of lexer tokens against the statement grammar.
// Input channel s_*: one token word per handshake (token kind, keyword code).
// Result channel m_*: one result word per token (accepted, parse state,
// scope depth, stack overflow), in token order.
// Throughput: one token per cycle while s_tready is high. Each result is
// registered in the output or, on a stall, the skid register. The return
// stack lives in a RAM with two registered read ports that always hold the
// entries at the stack level and one below it; a push in the same cycle is
// forwarded, so up to two pops and one push complete per token.
// Reset: parse state idle, depth zero; stack entries hold garbage until
// pushed and take no clearing pass.
// Stall: results queue in an output register and a skid register; s_tready
// drops only when both hold a word that m_tready has not yet taken.
`include "assert_macros.svh"

module token_grammar_pushdown_recognizer_unit #(
    parameter int STACK_DEPTH = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [4:0] token_kind, [6:5] keyword_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata    // [0] accepted, [4:1] parse_state,
                                   // [8:5] scope_depth, [9] stack_overflow
);

    import tgpr_pkg::*;

    localparam int LW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam logic [LW-1:0] LEVEL_FULL = LW'(STACK_DEPTH - 1);

    logic [3:0]    state_reg, state_next;
    logic [LW-1:0] level_reg, level_next;
    logic          fwd_reg;
    logic [3:0]    fwd_data_reg;

    logic [4:0]    tok;
    logic [1:0]    kw;
    logic          fire;
    logic [3:0]    rd_top, rd_below, top_a;
    logic [LW-1:0] addr_below;

    logic          helper_pop;
    logic [3:0]    s1, after1;
    logic [LW-1:0] l1, l2, lx;
    judge_t        j1, j2, jf;
    logic [3:0]    step_state;
    logic [LW-1:0] step_level;
    logic          step_acc, step_ovf, step_push;
    logic [LW+3:0] depth_ext;
    logic [15:0]   result;

    assign tok  = s_tdata[4:0];
    assign kw   = s_tdata[6:5];
    assign fire = s_tvalid && s_tready;

    // forward a push made in the previous cycle over the stale read
    assign top_a = fwd_reg ? fwd_data_reg : rd_top;

    always_comb begin
        helper_pop = (state_reg == S_HELPER) && (level_reg != '0);
        s1     = helper_pop ? top_a : state_reg;
        l1     = helper_pop ? level_reg - LW'(1) : level_reg;
        after1 = helper_pop ? rd_below : top_a;
        j1     = judge(s1, tok, kw, l1 != '0);
        l2     = l1 - LW'(1);
        j2     = judge(after1, tok, kw, l2 != '0);
        if (j1.act == ACT_RETRY) begin
            lx = l2;
            jf = j2;
            if (j2.act == ACT_RETRY) begin
                jf.act   = ACT_GO;
                jf.state = S_INVALID;
                jf.acc   = 1'b0;
            end
        end else begin
            lx = l1;
            jf = j1;
        end

        step_ovf   = 1'b0;
        step_push  = 1'b0;
        step_state = jf.state;
        step_acc   = jf.acc;
        step_level = lx;
        if (jf.act == ACT_PUSH) begin
            if (lx == LEVEL_FULL) begin
                step_ovf   = 1'b1;
                step_state = S_INVALID;
                step_acc   = 1'b0;
            end else begin
                step_push  = 1'b1;
                step_level = lx + LW'(1);
            end
        end

        state_next = fire ? step_state : state_reg;
        level_next = fire ? step_level : level_reg;
        addr_below = (level_next == '0) ? '0 : level_next - LW'(1);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            level_reg <= '0;
            fwd_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            level_reg <= level_next;
            fwd_reg   <= fire && step_push;
        end
        fwd_data_reg <= jf.ret;
    end

    tgpr_ram #(
        .WIDTH(4),
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .aclk    (aclk),
        .we      (fire && step_push),
        .waddr   (level_next),
        .wdata   (jf.ret),
        .raddr_a (level_next),
        .rdata_a (rd_top),
        .raddr_b (addr_below),
        .rdata_b (rd_below)
    );

    assign depth_ext = {4'b0000, step_level};
    assign result    = {6'b000000, step_ovf, depth_ext[3:0], step_state, step_acc};

    tgpr_skid #(
        .WIDTH(16)
    ) u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .in_data   (result),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_data  (m_tdata)
    );

    `ASSERT_IMPL(a_ovf_invalid, aclk, aresetn, fire && step_ovf, (step_state == S_INVALID) && !step_acc, "overflow without invalid state")
    `ASSERT_NEXT(a_hold_idle, aclk, aresetn, !fire, $stable(state_reg) && $stable(level_reg), "state moved without a word")
    `ASSERT_IMPL(a_fwd_level, aclk, aresetn, fwd_reg, level_reg != '0, "forwarded push at empty stack")
    `ASSERT_NEXT(a_level_step, aclk, aresetn, fire, {1'b0, level_reg} <= {1'b0, $past(level_reg)} + 1'b1, "stack grew by more than one")

endmodule

// ===== src/tgpr_ram.sv =====
// Generic RAM: one write port, two registered read ports.
module tgpr_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr_a,
    output logic [WIDTH-1:0] rdata_a,
    input  logic [AW-1:0]    raddr_b,
    output logic [WIDTH-1:0] rdata_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_a <= mem[raddr_a];
        rdata_b <= mem[raddr_b];
    end

endmodule

// ===== src/tgpr_skid.sv =====
// Two-entry output buffer: output register plus skid register.
module tgpr_skid #(
    parameter int WIDTH = 16
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             in_valid,
    output logic             in_ready,
    input  logic [WIDTH-1:0] in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [WIDTH-1:0] out_data
);

    logic             out_valid_reg, out_valid_next;
    logic [WIDTH-1:0] out_data_reg, out_data_next;
    logic             skid_valid_reg, skid_valid_next;
    logic [WIDTH-1:0] skid_data_reg, skid_data_next;
    logic             in_fire;

    assign in_ready  = !skid_valid_reg;
    assign in_fire   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_ready) begin
            // advance: skid word first, then the incoming word
            out_valid_next  = skid_valid_reg || in_fire;
            out_data_next   = skid_valid_reg ? skid_data_reg : in_data;
            skid_valid_next = 1'b0;
        end else if (in_fire) begin
            skid_valid_next = 1'b1;
            skid_data_next  = in_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end else begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

endmodule
